// ----- design/svsg_pkg.sv -----
// svsg_pkg: shared types and constants of the state vector swap gate unit
// item kinds, register indexes, controller states and command/status structs
// no dependencies
`timescale 1ns / 1ps

package svsg_pkg;

    localparam int ADDR_W    = 10;
    localparam int WORD_W    = 64;
    localparam int CFG_W     = 4;
    localparam int CFG_IDX_W = 2;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_READ  = 2'd1;
    localparam logic [1:0] KIND_SWAP  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_QUBIT_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_QUBIT_SECOND = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM_QUBITS   = 2'd2;

    localparam logic [CFG_W-1:0] QUBIT_FIRST_RST  = 4'd0;
    localparam logic [CFG_W-1:0] QUBIT_SECOND_RST = 4'd1;
    localparam logic [CFG_W-1:0] NUM_QUBITS_RST   = 4'd10;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD_DATA,
        ST_SW_START,
        ST_SW_READ,
        ST_SW_WR_A,
        ST_SW_WR_B,
        ST_SW_DONE
    } svsg_state_t;

    typedef struct packed {
        logic wr_host;
        logic rd_host;
        logic sw_load;
        logic sw_read;
        logic sw_wr_a;
        logic sw_wr_b;
        logic out_load_read;
        logic out_load_done;
    } svsg_cmd_t;

    typedef struct packed {
        logic sw_noop;
        logic sw_last;
        logic out_free;
    } svsg_status_t;

endpackage

// ----- design/svsg_ram.sv -----
// svsg_ram: generic single write port, dual read port memory
// read data registered, held while the read enable is low
// no dependencies
`timescale 1ns / 1ps

module svsg_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic                     re_b,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re_a) begin
            rdata_a_reg <= mem[raddr_a];
        end
        if (re_b) begin
            rdata_b_reg <= mem[raddr_b];
        end
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

// ----- design/svsg_ctrl.sv -----
// svsg_ctrl: controller state machine of the swap gate unit
// sequences host reads, writes and the pairwise swap sweep; depends on svsg_pkg
`timescale 1ns / 1ps

module svsg_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_kind,
    input  svsg_pkg::svsg_status_t status,
    output svsg_pkg::svsg_cmd_t    cmd
);
    import svsg_pkg::*;

    svsg_state_t state_reg;
    svsg_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (s_kind)
                        KIND_WRITE: begin
                            cmd.wr_host = 1'b1;
                        end
                        KIND_READ: begin
                            cmd.rd_host = 1'b1;
                            state_next  = ST_RD_DATA;
                        end
                        KIND_SWAP: begin
                            cmd.sw_load = 1'b1;
                            state_next  = ST_SW_START;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_RD_DATA: begin
                if (status.out_free) begin
                    cmd.out_load_read = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            ST_SW_START: begin
                if (status.sw_noop) begin
                    state_next = ST_SW_DONE;
                end else begin
                    cmd.sw_read = 1'b1;
                    state_next  = ST_SW_WR_A;
                end
            end
            ST_SW_READ: begin
                cmd.sw_read = 1'b1;
                state_next  = ST_SW_WR_A;
            end
            ST_SW_WR_A: begin
                cmd.sw_wr_a = 1'b1;
                state_next  = ST_SW_WR_B;
            end
            ST_SW_WR_B: begin
                cmd.sw_wr_b = 1'b1;
                state_next  = status.sw_last ? ST_SW_DONE : ST_SW_READ;
            end
            ST_SW_DONE: begin
                if (status.out_free) begin
                    cmd.out_load_done = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- design/svsg_datapath.sv -----
// svsg_datapath: configuration registers, amplitude memory, sweep index logic
// and result register; depends on svsg_pkg and svsg_ram
`timescale 1ns / 1ps

module svsg_datapath #(
    parameter int MAX_QUBITS = 10
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [svsg_pkg::ADDR_W-1:0]          s_address,
    input  logic [svsg_pkg::WORD_W-1:0]          s_real_word,
    input  logic [svsg_pkg::WORD_W-1:0]          s_imag_word,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic [svsg_pkg::WORD_W-1:0]          m_out_real,
    output logic [svsg_pkg::WORD_W-1:0]          m_out_imag,
    output logic                                 m_swap_done,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [svsg_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [svsg_pkg::CFG_W-1:0]           cfg_data,
    input  svsg_pkg::svsg_cmd_t                  cmd,
    output svsg_pkg::svsg_status_t               status
);
    import svsg_pkg::*;

    localparam int AW    = MAX_QUBITS;
    localparam int DEPTH = 1 << MAX_QUBITS;
    localparam int NQW   = ($clog2(MAX_QUBITS + 1) > CFG_W) ? $clog2(MAX_QUBITS + 1) : CFG_W;
    localparam logic [NQW-1:0] NQ_MAX = NQW'(MAX_QUBITS);
    localparam logic [NQW-1:0] NQ_MIN = NQW'(2);

    // configuration
    logic [CFG_W-1:0] qubit_first_reg;
    logic [CFG_W-1:0] qubit_second_reg;
    logic [CFG_W-1:0] num_qubits_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qubit_first_reg  <= QUBIT_FIRST_RST;
            qubit_second_reg <= QUBIT_SECOND_RST;
            num_qubits_reg   <= NUM_QUBITS_RST;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_QUBIT_FIRST:  qubit_first_reg  <= cfg_data;
                CFG_QUBIT_SECOND: qubit_second_reg <= cfg_data;
                CFG_NUM_QUBITS:   num_qubits_reg   <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg_ready = 1'b1;

    // effective length and address mask
    logic [NQW-1:0]   num_ext;
    logic [NQW-1:0]   nq_eff;
    logic [AW-1:0]    dim_mask;
    logic [AW-1:0]    host_addr;
    logic [NQW-1:0]   q0_ext;
    logic [NQW-1:0]   q1_ext;
    logic [CFG_W-1:0] lo;
    logic [CFG_W-1:0] hi;
    logic [CFG_W-1:0] hi_m1;
    logic [AW-1:0]    lo_fill;
    logic [AW-1:0]    below_hi;

    always_comb begin
        num_ext = NQW'(num_qubits_reg);
        if (num_ext < NQ_MIN) begin
            nq_eff = NQ_MIN;
        end else if (num_ext > NQ_MAX) begin
            nq_eff = NQ_MAX;
        end else begin
            nq_eff = num_ext;
        end
        dim_mask  = (AW'(1) << nq_eff) - AW'(1);
        host_addr = AW'(s_address) & dim_mask;
        q0_ext    = NQW'(qubit_first_reg);
        q1_ext    = NQW'(qubit_second_reg);
        lo        = (qubit_first_reg < qubit_second_reg) ? qubit_first_reg : qubit_second_reg;
        hi        = (qubit_first_reg < qubit_second_reg) ? qubit_second_reg : qubit_first_reg;
        hi_m1     = hi - CFG_W'(1);
        lo_fill   = (AW'(1) << lo) - AW'(1);
        below_hi  = (AW'(1) << hi_m1) - AW'(1);
    end

    // sweep setup, latched at the start of an apply
    logic [AW-1:0] low_reg;
    logic [AW-1:0] mid_reg;
    logic [AW-1:0] high_reg;
    logic [AW-1:0] m0_reg;
    logic [AW-1:0] both_reg;
    logic [AW-1:0] limit_reg;
    logic          noop_reg;
    logic [AW-1:0] cnt_reg;
    logic [AW-1:0] a_reg;
    logic [AW-1:0] b_reg;
    logic [AW-1:0] a_next;
    logic [AW-1:0] b_next;

    always_ff @(posedge aclk) begin
        if (cmd.sw_load) begin
            low_reg   <= lo_fill;
            mid_reg   <= below_hi ^ lo_fill;
            high_reg  <= ~below_hi;
            m0_reg    <= AW'(1) << qubit_first_reg;
            both_reg  <= (AW'(1) << qubit_first_reg) | (AW'(1) << qubit_second_reg);
            limit_reg <= (AW'(1) << (nq_eff - NQ_MIN)) - AW'(1);
            noop_reg  <= (qubit_first_reg == qubit_second_reg) || (q0_ext >= nq_eff)
                         || (q1_ext >= nq_eff);
        end
        if (cmd.sw_read) begin
            a_reg <= a_next;
            b_reg <= b_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.sw_load) begin
            cnt_reg <= '0;
        end else if (cmd.sw_wr_b) begin
            cnt_reg <= cnt_reg + AW'(1);
        end
    end

    // zero bits inserted at both targets, first target bit set
    always_comb begin
        a_next = ((cnt_reg & low_reg) | ((cnt_reg & mid_reg) << 1)
                 | ((cnt_reg & high_reg) << 2) | m0_reg) & dim_mask;
        b_next = (a_next ^ both_reg) & dim_mask;
    end

    // amplitude memory
    logic                  mem_we;
    logic [AW-1:0]         mem_waddr;
    logic [2*WORD_W-1:0]   mem_wdata;
    logic [AW-1:0]         mem_raddr_a;
    logic [2*WORD_W-1:0]   rdata_a;
    logic [2*WORD_W-1:0]   rdata_b;

    always_comb begin
        mem_we      = cmd.wr_host | cmd.sw_wr_a | cmd.sw_wr_b;
        mem_waddr   = host_addr;
        mem_wdata   = {s_real_word, s_imag_word};
        mem_raddr_a = cmd.rd_host ? host_addr : a_next;
        if (cmd.sw_wr_a) begin
            mem_waddr = a_reg;
            mem_wdata = rdata_b;
        end else if (cmd.sw_wr_b) begin
            mem_waddr = b_reg;
            mem_wdata = rdata_a;
        end
    end

    svsg_ram #(
        .WIDTH(2 * WORD_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (mem_we),
        .waddr   (mem_waddr),
        .wdata   (mem_wdata),
        .re_a    (cmd.rd_host | cmd.sw_read),
        .raddr_a (mem_raddr_a),
        .rdata_a (rdata_a),
        .re_b    (cmd.sw_read),
        .raddr_b (b_next),
        .rdata_b (rdata_b)
    );

    // result register
    logic              m_valid_reg;
    logic [WORD_W-1:0] m_out_real_reg;
    logic [WORD_W-1:0] m_out_imag_reg;
    logic              m_swap_done_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load_read || cmd.out_load_done) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load_read) begin
            m_out_real_reg  <= rdata_a[2*WORD_W-1:WORD_W];
            m_out_imag_reg  <= rdata_a[WORD_W-1:0];
            m_swap_done_reg <= 1'b0;
        end else if (cmd.out_load_done) begin
            m_out_real_reg  <= '0;
            m_out_imag_reg  <= '0;
            m_swap_done_reg <= 1'b1;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_out_real  = m_out_real_reg;
    assign m_out_imag  = m_out_imag_reg;
    assign m_swap_done = m_swap_done_reg;

    assign status.sw_noop  = noop_reg;
    assign status.sw_last  = (cnt_reg == limit_reg);
    assign status.out_free = !m_valid_reg || m_ready;

endmodule

// ----- design/state_vector_swap_gate_unit.sv -----
// state_vector_swap_gate_unit: a write goes straight to memory, a read goes to the result register
// apply swap: pairs are swapped one at a time, both read on the memory ports, then each written back
// apply with equal or out-of-range targets skips the sweep; one item in work at a time
// synchronous active-low reset clears the controller, config and result valid
// amplitude memory is not cleared: contents undefined until written
// depends on svsg_pkg, svsg_ctrl, svsg_datapath, svsg_ram
`timescale 1ns / 1ps

module state_vector_swap_gate_unit #(
    parameter int MAX_QUBITS = 10
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [1:0]                     s_kind,
    input  logic [svsg_pkg::ADDR_W-1:0]    s_address,
    input  logic [svsg_pkg::WORD_W-1:0]    s_real_word,
    input  logic [svsg_pkg::WORD_W-1:0]    s_imag_word,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [svsg_pkg::WORD_W-1:0]    m_out_real,
    output logic [svsg_pkg::WORD_W-1:0]    m_out_imag,
    output logic                           m_swap_done,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [svsg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [svsg_pkg::CFG_W-1:0]     cfg_data
);
    import svsg_pkg::*;

    svsg_cmd_t    cmd;
    svsg_status_t status;

    svsg_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_kind  (s_kind),
        .status  (status),
        .cmd     (cmd)
    );

    svsg_datapath #(
        .MAX_QUBITS(MAX_QUBITS)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_address   (s_address),
        .s_real_word (s_real_word),
        .s_imag_word (s_imag_word),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_out_real  (m_out_real),
        .m_out_imag  (m_out_imag),
        .m_swap_done (m_swap_done),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .cmd         (cmd),
        .status      (status)
    );

endmodule

// ----- design/svsg_checker.sv -----
// svsg_checker: port-level assertions for state_vector_swap_gate_unit
// bound to the top level below; depends on svsg_pkg
`timescale 1ns / 1ps

module svsg_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_valid,
    input logic                           s_ready,
    input logic [1:0]                     s_kind,
    input logic                           m_valid,
    input logic                           m_ready,
    input logic [svsg_pkg::WORD_W-1:0]    m_out_real,
    input logic [svsg_pkg::WORD_W-1:0]    m_out_imag,
    input logic                           m_swap_done
);
    import svsg_pkg::*;

    // no result word straight after reset
    assert property (@(posedge aclk) !aresetn |=> !m_valid)
        else $error("result word valid after reset");

    // stalled result word holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_out_real) && $stable(m_out_imag)
                                && $stable(m_swap_done))
        else $error("stalled result word changed");

    // completion word carries zero data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_swap_done |-> m_out_real == '0 && m_out_imag == '0)
        else $error("completion word with non-zero data");

    // a read or an apply keeps the input side closed for the next cycle
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && (s_kind == KIND_READ || s_kind == KIND_SWAP) |=> !s_ready)
        else $error("input taken while a read or apply is in work");

endmodule

bind state_vector_swap_gate_unit svsg_checker u_svsg_checker (.*);
